[src/assert_macros.svh]
// Assertion macros for the timestamp blob encoder RTL (used by tsb_ser).
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// a holds -> b holds in the same cycle
`define ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, a, b)
`define ASSERT_NEXT(label, a, b)
`endif
`endif

[src/tsb_pkg.sv]
// Types and constants for the timestamp blob encoder.
// No dependencies; used by tsb_ser, the top level and the testbench.
package tsb_pkg;

  // nanosecond range and fraction arithmetic
  localparam logic [29:0] NsPerSec     = 30'd1000000000;
  localparam logic [31:0] Recip5       = 32'hCCCCCCCD;   // ceil(2^34 / 5)
  localparam int          Recip5Shift  = 34;
  localparam logic [30:0] FracRound    = 31'd195312;
  localparam logic [30:0] FracDiv      = 31'd390625;
  localparam logic [21:0] RecipDiv     = 22'd2814749;    // floor(2^40 / 390625)
  localparam int          RecipDivShift = 40;
  localparam int          FracBits     = 12;

  // header byte fields: tag, length, blob type
  localparam logic [1:0]  HdrTag       = 2'b10;
  localparam logic [2:0]  BlobType     = 3'd5;

  // seconds bytes to send (0..5)
  localparam logic [2:0]  NbZero  = 3'd0;
  localparam logic [2:0]  NbOne   = 3'd1;
  localparam logic [2:0]  NbTwo   = 3'd2;
  localparam logic [2:0]  NbThree = 3'd3;
  localparam logic [2:0]  NbFour  = 3'd4;
  localparam logic [2:0]  NbFive  = 3'd5;

  // one finished item, handed from the arithmetic pipeline to the serializer
  typedef struct packed {
    logic        valid;
    logic [39:0] high;    // whole_seconds >> 4
    logic [2:0]  nb;      // significant bytes of high
    logic [15:0] tail;    // seconds nibble plus rounded fraction
  } tsb_load_t;

endpackage

[src/tsb_if.sv]
// Valid/ready channel interfaces of the timestamp blob encoder.
// No dependencies.
interface tsb_stamp_if;
  logic        valid;
  logic        ready;
  logic [43:0] whole_seconds;
  logic [29:0] subsecond_ns;

  modport source (output valid, output whole_seconds, output subsecond_ns, input ready);
  modport sink   (input valid, input whole_seconds, input subsecond_ns, output ready);
endinterface

interface tsb_blob_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

[src/tsb_ser.sv]
// Byte serializer: turns one finished item into header, seconds and tail words.
// Depends on tsb_pkg, tsb_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module tsb_ser import tsb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tsb_load_t load,
  output logic      load_ready,
  tsb_blob_if.source blob
);

  logic        valid;
  logic [3:0]  cnt;      // words left in this blob
  logic [63:0] sh;       // remaining words, next one at the top
  logic        ld_fire;
  logic        out_fire;
  logic        at_last;
  logic [2:0]  len;
  logic [55:0] body;
  logic [55:0] body_raw;

  assign at_last    = (cnt == 4'd1);
  assign out_fire   = valid && blob.ready;
  assign load_ready = !valid || (blob.ready && at_last);
  assign ld_fire    = load.valid && load_ready;

  // drop the leading zero bytes of the seconds so the blob starts packed
  assign body_raw = {load.high, load.tail};
  assign len      = load.nb + 3'd2;
  always_comb begin
    unique case (load.nb)
      NbZero:  body = body_raw << 40;
      NbOne:   body = body_raw << 32;
      NbTwo:   body = body_raw << 24;
      NbThree: body = body_raw << 16;
      NbFour:  body = body_raw << 8;
      NbFive:  body = body_raw;
      default: body = body_raw;
    endcase
  end

  // control: word count and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= 4'd0;
    end else if (ld_fire) begin
      valid <= 1'b1;
      cnt   <= {1'b0, load.nb} + 4'd3;
    end else if (out_fire) begin
      cnt <= cnt - 4'd1;
      if (at_last) begin
        valid <= 1'b0;
      end
    end
  end

  // payload: shift out one word per accept
  always_ff @(posedge clk) begin
    if (ld_fire) begin
      sh <= {HdrTag, len, BlobType, body};
    end else if (out_fire) begin
      sh <= sh << 8;
    end
  end

  assign blob.valid     = valid;
  assign blob.out_byte  = sh[63:56];
  assign blob.last_byte = at_last;

  `ASSERT_IMPLIES(a_cnt_range, valid, (cnt != 4'd0) && (cnt <= 4'd8))
  `ASSERT_IMPLIES(a_idle_empty, !valid, cnt == 4'd0)
  `ASSERT_NEXT(a_no_gap, out_fire && !at_last, blob.valid)
  `ASSERT_NEXT(a_header, ld_fire, (blob.out_byte[7:6] == HdrTag) && (blob.out_byte[2:0] == BlobType))

endmodule

[src/timestamp_blob_encoder.sv]
// Top level of the timestamp blob encoder: fraction pipeline plus serializer.
// Depends on tsb_pkg, tsb_if.sv and tsb_ser.
//
//   channel  dir  payload                               words per item
//   stamp    in   whole_seconds[43:0], subsecond_ns[29:0]  1
//   blob     out  out_byte[7:0], last_byte                 3 to 8
//
// Five register stages compute the fraction (mod, /5, /390625 estimate,
// correction, tail add); the serializer then sends one word per cycle while
// blob is ready. An item is 3 + (significant bytes of whole_seconds >> 4)
// words, 8 at most; the serializer sets the rate. The first blob word is
// valid once its stamp word has passed stages A to E and the serializer load.
// Synchronous reset clears all valid bits. A stall at blob backs up stage by
// stage; nothing is dropped or repeated.

module timestamp_blob_encoder import tsb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tsb_stamp_if.sink  stamp,
  tsb_blob_if.source blob
);

  // stage A: ns reduced, seconds split
  logic        a_valid, a_ready;
  logic [29:0] a_ns;
  logic [39:0] a_high;
  logic [3:0]  a_nib;
  logic [2:0]  a_nb;
  // stage B: ns / 5
  logic        b_valid, b_ready;
  logic [27:0] b_q5;
  logic [39:0] b_high;
  logic [3:0]  b_nib;
  logic [2:0]  b_nb;
  // stage C: dividend and quotient estimate
  logic        c_valid, c_ready;
  logic [30:0] c_x;
  logic [12:0] c_q0;
  logic [39:0] c_high;
  logic [3:0]  c_nib;
  logic [2:0]  c_nb;
  // stage D: correction flag
  logic        d_valid, d_ready;
  logic [12:0] d_q0;
  logic        d_ge;
  logic [39:0] d_high;
  logic [3:0]  d_nib;
  logic [2:0]  d_nb;
  // stage E: tail word
  logic        e_valid, e_ready;
  logic [15:0] e_tail;
  logic [39:0] e_high;
  logic [2:0]  e_nb;

  logic        load_ready;
  tsb_load_t   load;

  logic [39:0] in_high;
  logic [2:0]  in_nb;
  logic [61:0] prod5;
  logic [30:0] x_next;
  logic [52:0] prod_div;
  logic [30:0] rem;
  logic [12:0] frac;

  // per-stage ready: a stage moves when empty or when its successor moves
  assign a_ready = !a_valid || b_ready;
  assign b_ready = !b_valid || c_ready;
  assign c_ready = !c_valid || d_ready;
  assign d_ready = !d_valid || e_ready;
  assign e_ready = !e_valid || load_ready;
  assign stamp.ready = a_ready;

  // significant bytes of the high seconds
  assign in_high = stamp.whole_seconds[43:4];
  always_comb begin
    priority if (in_high[39:32] != 8'd0) begin
      in_nb = NbFive;
    end else if (in_high[31:24] != 8'd0) begin
      in_nb = NbFour;
    end else if (in_high[23:16] != 8'd0) begin
      in_nb = NbThree;
    end else if (in_high[15:8] != 8'd0) begin
      in_nb = NbTwo;
    end else if (in_high[7:0] != 8'd0) begin
      in_nb = NbOne;
    end else begin
      in_nb = NbZero;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= stamp.valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
      if (e_ready) e_valid <= d_valid;
    end
  end

  // stage A: reduce ns below one second (one subtract suffices for 30 bits)
  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_ns   <= (stamp.subsecond_ns >= NsPerSec) ? stamp.subsecond_ns - NsPerSec
                                                 : stamp.subsecond_ns;
      a_high <= in_high;
      a_nib  <= stamp.whole_seconds[3:0];
      a_nb   <= in_nb;
    end
  end

  // stage B: ns / 5 by reciprocal, exact for 32-bit inputs
  assign prod5 = 62'(a_ns) * 62'(Recip5);
  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_q5   <= prod5[61:Recip5Shift];
      b_high <= a_high;
      b_nib  <= a_nib;
      b_nb   <= a_nb;
    end
  end

  // stage C: x = q5*8 + round; quotient estimate, low by at most one
  assign x_next   = {b_q5, 3'b000} + FracRound;
  assign prod_div = 53'(x_next) * 53'(RecipDiv);
  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_x    <= x_next;
      c_q0   <= prod_div[52:RecipDivShift];
      c_high <= b_high;
      c_nib  <= b_nib;
      c_nb   <= b_nb;
    end
  end

  // stage D: remainder check decides the +1 correction
  assign rem = c_x - 31'(c_q0) * FracDiv;
  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_q0   <= c_q0;
      d_ge   <= (rem >= FracDiv);
      d_high <= c_high;
      d_nib  <= c_nib;
      d_nb   <= c_nb;
    end
  end

  // stage E: tail = (nibble << 12) + frac, carry past bit 15 dropped
  assign frac = d_q0 + 13'(d_ge);
  always_ff @(posedge clk) begin
    if (e_ready) begin
      e_tail <= {d_nib, 12'd0} + 16'(frac);
      e_high <= d_high;
      e_nb   <= d_nb;
    end
  end

  assign load.valid = e_valid;
  assign load.high  = e_high;
  assign load.nb    = e_nb;
  assign load.tail  = e_tail;

  tsb_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_ready (load_ready),
    .blob       (blob)
  );

endmodule

[dv/timestamp_blob_encoder_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for timestamp_blob_encoder: drives time stamps on the
// stamp channel and checks every blob word against directed expected bytes or a built-in encoder model.
// Depends on tsb_pkg, tsb_if.sv and the timestamp_blob_encoder RTL.

module timestamp_blob_encoder_test;
  import tsb_pkg::*;

  localparam int          RandomItems = 320;
  localparam int          QuietItems  = 60;     // last random items, no idling
  localparam int          StallLimit  = 2000;   // cycles with no word moving
  localparam int          DrainCycles = 40;
  localparam logic [31:0] NsWrap      = 32'd1000000000;
  localparam logic [31:0] RoundBias   = 32'd195312;
  localparam logic [31:0] FracDivisor = 32'd390625;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } blob_word_t;

  // n_bytes == 0: expected blob comes from encode_stamp
  typedef struct {
    logic [43:0] secs;
    logic [29:0] ns;
    int          n_bytes;
    logic [63:0] bytes;   // right-aligned, header in the top used byte
  } stamp_row_t;

  logic clk = 1'b0;
  logic rst;
  bit   idle_enable = 1'b1;
  int   errors = 0;
  int   quiet_cycles = 0;
  blob_word_t blob_words_due[$];

  tsb_stamp_if stamp();
  tsb_blob_if  blob();

  timestamp_blob_encoder i_dut (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp),
    .blob  (blob)
  );

  always #6 clk = ~clk;

  stamp_row_t directed_rows [23] = '{
    '{44'd0,              30'd0,          3, 64'h95_0000},
    '{44'd0,              30'd999999999,  3, 64'h95_1000},   // rounds up to 4096
    '{44'd15,             30'd999999999,  3, 64'h95_0000},   // carry out lost
    '{44'd0,              30'd1000000000, 3, 64'h95_0000},   // ns wraps
    '{44'd0,              30'h3FFFFFFF,   0, 64'd0},
    '{44'hFFF_FFFF_FFFF,  30'd0,          8, 64'hBDFF_FFFF_FFFF_F000},
    '{44'hFFF_FFFF_FFFF,  30'd999999999,  0, 64'd0},
    '{44'd16,             30'd0,          4, 64'h9D01_0000},
    '{44'hFF0,            30'd0,          4, 64'h9DFF_0000},
    '{44'h1000,           30'd0,          5, 64'hA5_0100_0000},
    '{44'hF_FFFF,         30'd0,          0, 64'd0},
    '{44'h10_0000,        30'd0,          0, 64'd0},
    '{44'hFFF_FFFF,       30'd0,          0, 64'd0},
    '{44'h1000_0000,      30'd0,          0, 64'd0},
    '{44'hF_FFFF_FFFF,    30'd0,          0, 64'd0},
    '{44'h10_0000_0000,   30'd0,          0, 64'd0},
    '{44'h100_0000_0000,  30'd0,          0, 64'd0},
    '{44'd7,              30'd1,          0, 64'd0},
    '{44'd8,              30'd122070,     0, 64'd0},
    '{44'hAAA_AAAA_AAAA,  30'h15555555,   0, 64'd0},
    '{44'h555_5555_5555,  30'h2AAAAAAA,   0, 64'd0},
    '{44'd3,              30'd999877929,  0, 64'd0},
    '{44'd3,              30'd999877930,  0, 64'd0}
  };

  // Blob for one time stamp: header, significant bytes of seconds >> 4,
  // then the seconds nibble plus rounded 12-bit fraction.
  function automatic void encode_stamp(input logic [43:0] secs, input logic [29:0] ns);
    logic [39:0] high;
    logic [31:0] ns_wrapped;
    logic [31:0] frac;
    logic [15:0] tail;
    int          nb;
    high = secs[43:4];
    nb = 0;
    for (int i = 0; i < 5; i++)
      if ((high >> (8 * i)) != 40'd0) nb = i + 1;
    ns_wrapped = ({2'b00, ns} >= NsWrap) ? {2'b00, ns} - NsWrap : {2'b00, ns};
    frac = (ns_wrapped / 32'd5 * 32'd8 + RoundBias) / FracDivisor;
    tail = {secs[3:0], 12'd0} + frac[15:0];
    blob_words_due.push_back('{data: {HdrTag, 3'(nb + 2), BlobType}, last: 1'b0});
    for (int k = nb - 1; k >= 0; k--)
      blob_words_due.push_back('{data: high[8 * k +: 8], last: 1'b0});
    blob_words_due.push_back('{data: tail[15:8], last: 1'b0});
    blob_words_due.push_back('{data: tail[7:0], last: 1'b1});
  endfunction

  // Seconds spread over every blob length, sometimes full width.
  function automatic logic [43:0] random_seconds();
    logic [63:0] r;
    int          nb;
    r = {$urandom, $urandom};
    nb = $urandom_range(0, 6);
    if (nb == 6) return r[43:0];
    return r[43:0] & ((44'd1 << (8 * nb + 4)) - 44'd1);
  endfunction

  function automatic logic [29:0] random_ns();
    case ($urandom_range(0, 9))
      0: return 30'($urandom_range(1000000000, 32'h3FFFFFFF));   // wraps
      1: return 30'(999999999 - $urandom_range(0, 300000));      // near round-up
      2: return 30'($urandom_range(0, 200000));
      default: return 30'($urandom_range(0, 999999999));
    endcase
  endfunction

  // Present one stamp word, hold it until accepted, then queue its blob.
  task automatic send_stamp(input logic [43:0] secs, input logic [29:0] ns,
                            input int n_bytes, input logic [63:0] bytes);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      stamp.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    stamp.valid         <= 1'b1;
    stamp.whole_seconds <= secs;
    stamp.subsecond_ns  <= ns;
    do @(posedge clk); while (!stamp.ready);
    if (n_bytes == 0) begin
      encode_stamp(secs, ns);
    end else begin
      for (int k = 0; k < n_bytes; k++)
        blob_words_due.push_back('{data: bytes[8 * (n_bytes - 1 - k) +: 8],
                                   last: (k == n_bytes - 1)});
    end
    @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    rst = 1'b1;
    stamp.valid = 1'b0;
    stamp.whole_seconds = '0;
    stamp.subsecond_ns = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_stamp(directed_rows[i].secs, directed_rows[i].ns,
                 directed_rows[i].n_bytes, directed_rows[i].bytes);
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - QuietItems) idle_enable = 1'b0;
      send_stamp(random_seconds(), random_ns(), 0, 64'd0);
    end
    stamp.valid <= 1'b0;
    wait (blob_words_due.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (blob_words_due.size() != 0) begin
      $display("%0t: %0d blob words never arrived", $time, blob_words_due.size());
      errors++;
    end
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Blob receiver: random stall bursts while idling is on
  initial begin
    blob.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        blob.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      blob.ready <= 1'b1;
    end
  end

  // Compare each accepted blob word with the oldest one due
  always @(posedge clk) begin : blob_check
    blob_word_t want;
    if (!rst && blob.valid && blob.ready) begin
      if (blob_words_due.size() == 0) begin
        $display("%0t: unexpected blob word: expected none, got %02h last %0b",
                 $time, blob.out_byte, blob.last_byte);
        errors++;
      end else begin
        want = blob_words_due.pop_front();
        if (blob.out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, got %02h",
                   $time, want.data, blob.out_byte);
          errors++;
        end
        if (blob.last_byte !== want.last) begin
          $display("%0t: last_byte mismatch: expected %0b, got %0b",
                   $time, want.last, blob.last_byte);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (stamp.valid && stamp.ready) || (blob.valid && blob.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StallLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
